### rtl/lsmr_pkg.sv
// Shared types, constants and tables for the lidar sector min-range summary.
package lsmr_pkg;

  localparam int MaxSectors  = 64;
  localparam int SecW        = 6;
  localparam int SecCntW     = 7;
  localparam int CordicSteps = 16;
  localparam int StepW       = 5;
  localparam int CordW       = 28;   // 16 bit input * 256 plus growth headroom
  localparam int SqrtSteps   = 16;   // 32-bit radicand, two bits per step

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_EOS   = 1'b1;

  localparam logic [1:0] REG_GATE_LOW  = 2'd0;
  localparam logic [1:0] REG_GATE_HIGH = 2'd1;
  localparam logic [1:0] REG_SECTORS   = 2'd2;

  // Binary angle step table, 65536 per turn.
  function automatic logic [15:0] atan_units(input logic [StepW-1:0] i);
    logic [15:0] v;
    unique case (i)
      5'd0:  v = 16'd8192;
      5'd1:  v = 16'd4836;
      5'd2:  v = 16'd2555;
      5'd3:  v = 16'd1297;
      5'd4:  v = 16'd651;
      5'd5:  v = 16'd326;
      5'd6:  v = 16'd163;
      5'd7:  v = 16'd81;
      5'd8:  v = 16'd41;
      5'd9:  v = 16'd20;
      5'd10: v = 16'd10;
      5'd11: v = 16'd5;
      5'd12: v = 16'd3;
      5'd13: v = 16'd1;
      5'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // latch input item, set up CORDIC and root
    logic iterate;    // one CORDIC step and one root step
    logic sec_mul;    // compute sector from angle
    logic update;     // fold kept point into statistics
    logic div_start;  // start mean division
    logic div_step;   // one restoring division step
    logic row_load;   // load output row for current sector
    logic clr_step;   // clear one sector entry, advance index
    logic clr_stats;  // clear scan statistics
  } lsmr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_eos;
    logic iter_done;
    logic div_done;
    logic row_last;   // current sector index is the last one
  } lsmr_sts_t;

endpackage

### rtl/lidar_sector_min_range_summary.sv
// Top level: config registers, stream ports, controller, datapath and output register.
//
//  channel  dir  payload                                            handshake
//  s_axis   in   tuser{command}, tdata{x_mm, y_mm}                  tvalid/tready
//  m_axis   out  tdata{sector row}, tlast                           tvalid/tready
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i                    write enable
//
// A point is accepted, then takes 16 shared CORDIC/root steps, a sector step and an update.
// End of scan: a setup step and 32 mean division steps, then a load and a push step per
// sector row and a clear step; rows wait while m_axis stalls.
// s_axis stays not ready until the summary is done. State clears after the final row.
// Reset clears statistics and sector hit bits; minima memory needs none.
module lidar_sector_min_range_summary (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,  // command
  input  logic [31:0] s_axis_tdata,  // x_mm[15:0], y_mm[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // sector_index, sector_min_range, sector_hit,
                                     // scan_min, scan_max, scan_mean, point_count
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import lsmr_pkg::*;

  logic [15:0] gate_low_q, gate_high_q;
  logic [6:0]  sec_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_low_q  <= 16'd50;
      gate_high_q <= 16'd10000;
      sec_cnt_q   <= 7'd36;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GATE_LOW:  gate_low_q  <= cfg_data_i;
        REG_GATE_HIGH: gate_high_q <= cfg_data_i;
        REG_SECTORS:   sec_cnt_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  lsmr_cmd_t cmd;
  lsmr_sts_t sts;
  logic      push;
  logic [87:0] row;
  logic      ovalid_q;
  logic [87:0] orow_q;

  lsmr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (ovalid_q && !m_axis_tready),
    .out_push_o (push),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsmr_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (s_axis_tuser),
    .in_x_i       (s_axis_tdata[15:0]),
    .in_y_i       (s_axis_tdata[31:16]),
    .gate_low_i   (gate_low_q),
    .gate_high_i  (gate_high_q),
    .sector_cnt_i (sec_cnt_q),
    .row_o        (row)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (push) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (push) orow_q <= row;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, orow_q[86:0]};
  assign m_axis_tlast  = orow_q[87];

  // never push over an unaccepted row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !(ovalid_q && !m_axis_tready)) else $error("row overwritten");
  // no input accepted while a row waits in the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !s_axis_tready) else $error("input taken during summary");
endmodule

### rtl/lsmr_ctrl.sv
// Controller state machine sequencing points, summary rows and clearing.
module lsmr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  output logic              out_push_o,
  input  lsmr_pkg::lsmr_sts_t sts_i,
  output lsmr_pkg::lsmr_cmd_t cmd_o
);
  import lsmr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ITER  = 8'b0000_0010,
    S_SEC   = 8'b0000_0100,
    S_UPD   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_ROW   = 8'b0010_0000,
    S_PUSH  = 8'b0100_0000,
    S_CLR   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_ITER;
        end
      end
      S_ITER: begin
        if (sts_i.is_eos) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.iterate = 1'b1;
          if (sts_i.iter_done) state_d = S_SEC;
        end
      end
      S_SEC: begin
        cmd_o.sec_mul = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d = S_IDLE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_ROW;
      end
      S_ROW: begin
        // wait for output register to free
        if (!out_busy_i) begin
          cmd_o.row_load = 1'b1;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        out_push_o = 1'b1;
        cmd_o.clr_step = 1'b1;
        state_d = sts_i.row_last ? S_CLR : S_ROW;
      end
      S_CLR: begin
        cmd_o.clr_stats = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

### rtl/lsmr_dp.sv
// Datapath: CORDIC angle, bitwise square root, statistics, sector table, mean divider.
module lsmr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsmr_pkg::lsmr_cmd_t cmd_i,
  output lsmr_pkg::lsmr_sts_t sts_o,
  input  logic                in_cmd_i,
  input  logic [15:0]         in_x_i,
  input  logic [15:0]         in_y_i,
  input  logic [15:0]         gate_low_i,
  input  logic [15:0]         gate_high_i,
  input  logic [6:0]          sector_cnt_i,
  output logic [87:0]         row_o
);
  import lsmr_pkg::*;

  // effective sector count, 1..MaxSectors
  logic [SecCntW-1:0] nsec;
  always_comb begin
    if (sector_cnt_i == '0) nsec = SecCntW'(1);
    else if (sector_cnt_i > SecCntW'(MaxSectors)) nsec = SecCntW'(MaxSectors);
    else nsec = sector_cnt_i;
  end

  logic              eos_q;
  logic signed [CordW-1:0] cx_q, cy_q;
  logic [15:0]       ang_q;
  logic [StepW-1:0]  step_q;
  logic              origin_q;
  logic [31:0]       rad_q, root_q;
  logic [31:0]       bit_q;
  logic [SecW-1:0]   sec_q;

  logic signed [16:0] xs, ys;
  logic signed [33:0] xx, yy;
  logic [33:0] sq;
  assign xs = $signed({in_x_i[15], in_x_i});
  assign ys = $signed({in_y_i[15], in_y_i});
  assign xx = xs * xs;
  assign yy = ys * ys;
  assign sq = xx + yy;

  // CORDIC step
  logic signed [CordW-1:0] dx, dy;
  assign dx = cy_q >>> step_q;
  assign dy = cx_q >>> step_q;

  // root step
  logic [31:0] trial;
  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      eos_q    <= in_cmd_i;
      step_q   <= '0;
      origin_q <= (in_x_i == 16'd0) && (in_y_i == 16'd0);
      if (in_x_i[15]) begin
        cx_q  <= CordW'(-xs) <<< 8;
        cy_q  <= CordW'(-ys) <<< 8;
        ang_q <= 16'h8000;
      end else begin
        cx_q  <= CordW'(xs) <<< 8;
        cy_q  <= CordW'(ys) <<< 8;
        ang_q <= 16'h0;
      end
      rad_q  <= sq[31:0];
      root_q <= '0;
      bit_q  <= 32'h4000_0000;
    end else if (cmd_i.iterate) begin
      step_q <= step_q + StepW'(1);
      if (!origin_q) begin
        if (cy_q > 0) begin
          cx_q  <= cx_q + dx;
          cy_q  <= cy_q - dy;
          ang_q <= ang_q + atan_units(step_q);
        end else begin
          cx_q  <= cx_q - dx;
          cy_q  <= cy_q + dy;
          ang_q <= ang_q - atan_units(step_q);
        end
      end
      if (rad_q >= trial) begin
        rad_q  <= rad_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end
  assign sts_o.iter_done = (step_q == StepW'(CordicSteps - 1));
  assign sts_o.is_eos    = eos_q;

  // sector from shifted angle
  logic [15:0] shifted;
  logic [22:0] prod;
  logic [SecW:0] sec_raw;
  assign shifted = ang_q + 16'h8000;
  assign prod    = 23'(shifted) * 23'(nsec);
  assign sec_raw = prod[22:16];
  always_ff @(posedge clk_i) begin
    if (cmd_i.sec_mul) begin
      if (sec_raw >= nsec) sec_q <= SecW'(nsec - SecCntW'(1));
      else                 sec_q <= sec_raw[SecW-1:0];
    end
  end

  // root is below 2^16 after 16 steps for a 32-bit radicand
  logic [16:0] r;
  logic        keep;
  assign r    = root_q[16:0];
  assign keep = (r >= {1'b0, gate_low_i}) && (r <= {1'b0, gate_high_i});

  // statistics and sector table
  logic [15:0] run_min_q, run_max_q, kept_q;
  logic [31:0] total_q;
  logic [15:0] smin_mem [MaxSectors];
  logic [MaxSectors-1:0] seen_q;
  logic [SecW-1:0] idx_q;
  logic [15:0] mem_rd_q;
  logic [15:0] mem_wr;
  logic        mem_we;
  logic [SecW-1:0] mem_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q <= 16'hFFFF;
      run_max_q <= '0;
      total_q   <= '0;
      kept_q    <= '0;
      seen_q    <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.update && keep) begin
        if (r[15:0] < run_min_q) run_min_q <= r[15:0];
        if (r[15:0] > run_max_q) run_max_q <= r[15:0];
        if (kept_q != 16'hFFFF) begin
          total_q <= total_q + 32'(r[15:0]);
          kept_q  <= kept_q + 16'd1;
        end
        seen_q[sec_q] <= 1'b1;
      end
      if (cmd_i.clr_step) begin
        seen_q[idx_q] <= 1'b0;
        idx_q <= sts_o.row_last ? '0 : idx_q + SecW'(1);
      end
      // hit bits beyond the current sector count clear here with the rest
      if (cmd_i.clr_stats) begin
        run_min_q <= 16'hFFFF;
        run_max_q <= '0;
        total_q   <= '0;
        kept_q    <= '0;
        seen_q    <= '0;
      end
    end
  end
  assign sts_o.row_last = (SecCntW'(idx_q) == nsec - SecCntW'(1));

  // sector minimum memory: read in S_SEC, write in S_UPD, read row in S_ROW
  assign mem_addr = cmd_i.update ? sec_q : (cmd_i.sec_mul ?
                    (sec_raw >= nsec ? SecW'(nsec - SecCntW'(1)) : sec_raw[SecW-1:0]) : idx_q);
  assign mem_we   = cmd_i.update && keep &&
                    (!seen_q[sec_q] || (r[15:0] < mem_rd_q));
  assign mem_wr   = r[15:0];
  always_ff @(posedge clk_i) begin
    if (mem_we) smin_mem[mem_addr] <= mem_wr;
    mem_rd_q <= smin_mem[mem_addr];
  end

  // restoring divider for the mean
  logic [31:0] quo_q;
  logic [16:0] rem_q;
  logic [StepW:0] dcnt_q;
  logic [16:0] rtry;
  assign rtry = {rem_q[15:0], quo_q[31]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q  <= total_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + (StepW+1)'(1);
      if (rtry >= {1'b0, kept_q}) begin
        rem_q <= rtry - {1'b0, kept_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rtry;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (dcnt_q == (StepW+1)'(31));

  // row assembly; memory data for the S_ROW address is registered and valid in S_PUSH
  logic        empty;
  logic [15:0] hit_min;
  assign empty   = (kept_q == '0);
  assign hit_min = seen_q[idx_q] ? mem_rd_q : 16'd0;
  assign row_o = {
    sts_o.row_last,
    kept_q,
    empty ? 16'd0 : quo_q[15:0],
    empty ? 16'd0 : run_max_q,
    empty ? 16'd0 : run_min_q,
    seen_q[idx_q],
    hit_min[15:0],
    idx_q
  };
endmodule

### bench/testbench.sv
// Self-checking bench for the lidar sector min-range summary block.
module testbench;
  import lsmr_pkg::*;

  localparam int CycleLimit = 400_000;
  localparam int DrainCycles = 80;

  // One summary row as the block reports it.
  typedef struct {
    logic [5:0]  sec;
    logic [15:0] sec_min;
    logic        hit;
    logic [15:0] scan_min;
    logic [15:0] scan_max;
    logic [15:0] scan_mean;
    logic [15:0] count;
    logic        last;
  } sector_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = 1'b0;  // command
  logic [31:0] s_axis_tdata = '0;    // x_mm[15:0], y_mm[31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;       // sector_index, sector_min_range, sector_hit,
                                   // scan_min, scan_max, scan_mean, point_count
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  lidar_sector_min_range_summary u_dut (.*);

  // Predictor state
  logic [15:0] gate_lo, gate_hi;
  logic [6:0]  sec_cfg;
  logic [15:0] sec_min_mem [MaxSectors];
  logic        sec_hit_mem [MaxSectors];
  logic [15:0] run_min, run_max, kept;
  logic [31:0] range_sum;

  sector_row_t summary_rows_q[$];
  bit          failed = 1'b0;
  bit          idle_en = 1'b0;
  int          hold_cycles = 0;
  longint      cycles = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL lidar_sector_min_range_summary");
      $finish;
    end
  end

  function automatic int unsigned floor_root(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 32;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return int'(root);
  endfunction

  function automatic logic [15:0] point_angle(longint x, longint y);
    logic [15:0] ang;
    longint dx, dy;
    logic [15:0] step_tab [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                   41, 20, 10, 5, 3, 1, 1, 0};
    ang = 16'd0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 16'd32768;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        ang += step_tab[i];
      end else begin
        x -= dx;
        y += dy;
        ang -= step_tab[i];
      end
    end
    return ang;
  endfunction

  function automatic void clear_scan();
    for (int i = 0; i < MaxSectors; i++) begin
      sec_min_mem[i] = 16'hFFFF;
      sec_hit_mem[i] = 1'b0;
    end
    run_min = 16'hFFFF;
    run_max = '0;
    range_sum = '0;
    kept = '0;
  endfunction

  // Fold one accepted item into the predicted scan; end of scan queues the rows.
  function automatic void predict_item(logic cmd, logic [15:0] xr, logic [15:0] yr);
    int n;
    int unsigned r, sec;
    logic [15:0] shifted;
    sector_row_t row;
    n = (sec_cfg < 1) ? 1 : (sec_cfg > MaxSectors) ? MaxSectors : int'(sec_cfg);
    if (cmd == CMD_POINT) begin
      r = floor_root(longint'($signed(xr)) * $signed(xr) + longint'($signed(yr)) * $signed(yr));
      if (r < gate_lo || r > gate_hi) return;
      if (r < run_min) run_min = r[15:0];
      if (r > run_max) run_max = r[15:0];
      if (kept != 16'hFFFF) begin
        range_sum += r;
        kept++;
      end
      shifted = point_angle($signed(xr), $signed(yr)) + 16'd32768;
      sec = (int'(shifted) * n) >> 16;
      if (sec >= n) sec = n - 1;
      if (r < sec_min_mem[sec]) sec_min_mem[sec] = r[15:0];
      sec_hit_mem[sec] = 1'b1;
    end else begin
      for (int k = 0; k < n; k++) begin
        row.sec = k[5:0];
        row.sec_min = sec_hit_mem[k] ? sec_min_mem[k] : 16'd0;
        row.hit = sec_hit_mem[k];
        row.scan_min = (kept != 0) ? run_min : 16'd0;
        row.scan_max = (kept != 0) ? run_max : 16'd0;
        row.scan_mean = (kept != 0) ? 16'(range_sum / kept) : 16'd0;
        row.count = kept;
        row.last = (k + 1 == n);
        summary_rows_q.push_back(row);
      end
      clear_scan();
    end
  endfunction

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  // Result check; inputs only move at rising edges, so the falling edge sees a stable transfer.
  always @(negedge clk_i) begin
    sector_row_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (summary_rows_q.size() == 0) begin
        $error("unexpected row tdata=%h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        e = summary_rows_q.pop_front();
        if (m_axis_tdata[5:0] !== e.sec) begin
          $error("sector_index exp %0d got %0d", e.sec, m_axis_tdata[5:0]); failed = 1'b1;
        end
        if (m_axis_tdata[21:6] !== e.sec_min) begin
          $error("sector_min_range exp %0d got %0d", e.sec_min, m_axis_tdata[21:6]);
          failed = 1'b1;
        end
        if (m_axis_tdata[22] !== e.hit) begin
          $error("sector_hit exp %0d got %0d", e.hit, m_axis_tdata[22]); failed = 1'b1;
        end
        if (m_axis_tdata[38:23] !== e.scan_min) begin
          $error("scan_min_range exp %0d got %0d", e.scan_min, m_axis_tdata[38:23]);
          failed = 1'b1;
        end
        if (m_axis_tdata[54:39] !== e.scan_max) begin
          $error("scan_max_range exp %0d got %0d", e.scan_max, m_axis_tdata[54:39]);
          failed = 1'b1;
        end
        if (m_axis_tdata[70:55] !== e.scan_mean) begin
          $error("scan_mean_range exp %0d got %0d", e.scan_mean, m_axis_tdata[70:55]);
          failed = 1'b1;
        end
        if (m_axis_tdata[86:71] !== e.count) begin
          $error("point_count exp %0d got %0d", e.count, m_axis_tdata[86:71]);
          failed = 1'b1;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, m_axis_tlast); failed = 1'b1;
        end
      end
    end
  end

  // Offer one item and hold it until the transfer. tvalid stays up afterwards until
  // the next item or a drain replaces it; the block is already busy with the item by then.
  task automatic send_item(logic cmd, logic [15:0] x, logic [15:0] y);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {y, x};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    predict_item(cmd, x, y);
  endtask

  task automatic send_point(int x, int y);
    send_item(CMD_POINT, x[15:0], y[15:0]);
  endtask

  task automatic end_scan();
    send_item(CMD_EOS, 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (summary_rows_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GATE_LOW:  gate_lo = val;
      REG_GATE_HIGH: gate_hi = val;
      REG_SECTORS:   sec_cfg = val[6:0];
      default: ;
    endcase
  endtask

  task automatic test_directed();
    send_point(0, 0);             // origin, below gate
    send_point(1000, 0);
    send_point(-1000, 0);         // negative x, half-turn start
    send_point(0, 1000);
    send_point(0, -1000);
    send_point(-700, -700);
    send_point(50, 0);            // low gate edge kept
    send_point(0, 49);            // just below gate
    send_point(10000, 0);         // high gate edge kept
    send_point(-10001, 0);        // just above gate
    send_point(-32768, -32768);
    send_point(32767, 32767);
    end_scan();
    end_scan();                   // empty scan
  endtask

  task automatic test_registers();
    write_reg(REG_GATE_LOW, 16'd0);
    write_reg(REG_GATE_HIGH, 16'hFFFF);
    write_reg(REG_SECTORS, 16'd64);
    send_point(0, 0);
    send_point(-32768, -32768);
    send_point(32767, -32768);
    send_point(-32768, 1);
    send_point(-5, 0);
    end_scan();
    write_reg(REG_SECTORS, 16'd1);
    send_point(300, -300);
    end_scan();
    write_reg(REG_SECTORS, 16'd0);  // acts as one sector
    send_point(-300, 300);
    end_scan();
    write_reg(REG_SECTORS, 16'd127); // clamps to the maximum
    send_point(123, 4567);
    end_scan();
    write_reg(REG_GATE_LOW, 16'hFFFF);
    write_reg(REG_GATE_HIGH, 16'd0);
    send_point(1, 1);
    end_scan();
  endtask

  // Rows back up under a receiver hold-off while the sender waits with further points.
  task automatic test_backpressure();
    write_reg(REG_GATE_LOW, 16'd50);
    write_reg(REG_GATE_HIGH, 16'd10000);
    write_reg(REG_SECTORS, 16'd36);
    send_point(800, 900);
    hold_cycles = 400;
    end_scan();
    for (int i = 0; i < 6; i++) send_point($urandom_range(0, 4000) - 2000, 1500);
    end_scan();
  endtask

  task automatic test_random();
    int sent;
    int mag;
    sent = 0;
    idle_en = 1'b1;
    while (sent < 160) begin
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_GATE_LOW, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300)));
        write_reg(REG_GATE_HIGH, $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                            : 16'($urandom_range(2000, 65535)));
        write_reg(REG_SECTORS, 16'($urandom_range(0, 127)));
      end
      repeat ($urandom_range(2, 20)) begin
        mag = ($urandom_range(0, 4) == 0) ? 32767 : 8000;
        if ($urandom_range(0, 5) == 0) send_point(int'($signed(16'($urandom))),
                                                  int'($signed(16'($urandom))));
        else send_point($urandom_range(0, 2 * mag) - mag, $urandom_range(0, 2 * mag) - mag);
        sent++;
      end
      end_scan();
      sent++;
    end
    idle_en = 1'b0;
  endtask

  // Closing stretch at full rate with no idling on either side.
  task automatic test_full_rate();
    write_reg(REG_GATE_LOW, 16'd0);
    write_reg(REG_GATE_HIGH, 16'hFFFF);
    write_reg(REG_SECTORS, 16'd64);
    send_point(-32768, -32768);
    send_point(32767, 32767);
    for (int i = 0; i < 18; i++) begin
      send_point(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
    end
    end_scan();
  endtask

  initial begin
    gate_lo = 16'd50;
    gate_hi = 16'd10000;
    sec_cfg = 7'd36;
    clear_scan();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_backpressure();
    test_random();
    test_full_rate();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed) begin
      $display("PASS lidar_sector_min_range_summary");
    end else begin
      $display("FAIL lidar_sector_min_range_summary");
    end
    $finish;
  end

endmodule
